### hw/rtl/rrcd_pkg.sv
// Shared types, constants and tables for the reflector run centroid detector.
// No dependencies; every other file of the block refers to this package by scoped names.
`default_nettype none

package rrcd_pkg;

	localparam int RANGE_W  = 16;
	localparam int INTEN_W  = 16;
	localparam int ANGLE_W  = 16;
	localparam int STEP_W   = 13;
	localparam int SUM_W    = 28;
	localparam int COUNT_W  = 11;
	localparam int LEGS_W   = 10;
	localparam int COORD_W  = 17;
	localparam int TRIG_W   = 16;
	localparam int CORD_W   = 18;
	localparam int PROD_W   = 33;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 16;

	localparam int DEF_MAX_SAMPLES = 1024;
	localparam int CORDIC_STEPS    = 15;

	localparam logic [INTEN_W-1:0] THRESH_RESET = 16'd7000;
	localparam logic [RANGE_W-1:0] MIN_RANGE_RESET = 16'd100;
	localparam logic [ANGLE_W-1:0] START_RESET = 16'h8000;
	localparam logic [STEP_W-1:0] STEP_RESET = 13'd91;

	localparam logic signed [CORD_W-1:0] CORDIC_X0 = 18'sd19899;
	localparam logic signed [CORD_W-1:0] Q15_MAX   = 18'sd32767;
	localparam logic [COUNT_W-1:0] POINT_MAX = 11'd2047;
	localparam logic [LEGS_W-1:0] LEGS_MAX = 10'd1023;
	localparam logic [LEGS_W-1:0] LEGS_PAIR = 10'd2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_THRESHOLD = 8'd0,
		REG_MIN_RANGE = 8'd1,
		REG_START     = 8'd2,
		REG_STEP      = 8'd3
	} reg_idx_t;

	typedef enum logic {
		KIND_LEG     = 1'b0,
		KIND_SUMMARY = 1'b1
	} kind_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ANGLE,
		ST_ROT_GO,
		ST_ROT_WAIT,
		ST_MUL,
		ST_ACC_X,
		ST_ACC_Y,
		ST_DIVX_GO,
		ST_DIVX_WAIT,
		ST_DIVY_GO,
		ST_DIVY_WAIT,
		ST_EMIT_LEG,
		ST_STEP,
		ST_EMIT_END
	} state_t;

	// Arctangent of 2^-i in binary angle units, 65536 units to the turn.
	function automatic logic [13:0] atan_lut(input logic [3:0] idx);
		logic [13:0] v;
		case (idx)
			4'd0:    v = 14'd8192;
			4'd1:    v = 14'd4836;
			4'd2:    v = 14'd2555;
			4'd3:    v = 14'd1297;
			4'd4:    v = 14'd651;
			4'd5:    v = 14'd326;
			4'd6:    v = 14'd163;
			4'd7:    v = 14'd81;
			4'd8:    v = 14'd41;
			4'd9:    v = 14'd20;
			4'd10:   v = 14'd10;
			4'd11:   v = 14'd5;
			4'd12:   v = 14'd3;
			4'd13:   v = 14'd1;
			4'd14:   v = 14'd1;
			default: v = 14'd0;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

### hw/rtl/rrcd_sample_if.sv
// Input sample channel of the reflector run centroid detector.
// Depends on rrcd_pkg for the field widths.
`default_nettype none

interface rrcd_sample_if;
	logic                          valid;
	logic                          ready;
	logic [rrcd_pkg::RANGE_W-1:0]  range_mm;
	logic [rrcd_pkg::INTEN_W-1:0]  intensity;
	logic                          scan_end;

	modport source (output valid, range_mm, intensity, scan_end, input ready);
	modport sink   (input valid, range_mm, intensity, scan_end, output ready);
endinterface

`default_nettype wire

### hw/rtl/rrcd_result_if.sv
// Result channel of the reflector run centroid detector.
// Depends on rrcd_pkg for the field widths.
`default_nettype none

interface rrcd_result_if;
	logic                                valid;
	logic                                ready;
	logic                                kind;
	logic signed [rrcd_pkg::COORD_W-1:0] leg_x_mm;
	logic signed [rrcd_pkg::COORD_W-1:0] leg_y_mm;
	logic [rrcd_pkg::LEGS_W-1:0]         leg_count;
	logic                                found_two;
	logic                                final_res;

	modport source (output valid, kind, leg_x_mm, leg_y_mm, leg_count, found_two, final_res,
		input ready);
	modport sink   (input valid, kind, leg_x_mm, leg_y_mm, leg_count, found_two, final_res,
		output ready);
endinterface

`default_nettype wire

### hw/rtl/rrcd_cfg_if.sv
// Configuration write channel of the reflector run centroid detector.
// Depends on rrcd_pkg for the index and data widths.
`default_nettype none

interface rrcd_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [rrcd_pkg::CFG_IDX_W-1:0]   index;
	logic [rrcd_pkg::CFG_DATA_W-1:0]  data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### hw/rtl/rrcd_cordic.sv
// Iterative rotation-mode CORDIC giving Q1.15 cosine and sine of a binary angle.
// One micro-rotation per cycle; depends on rrcd_pkg for widths and the arctangent table.
`default_nettype none

module rrcd_cordic (
	input  wire                                     clk,
	input  wire                                     arst_n,
	input  wire                                     start,
	input  wire [rrcd_pkg::ANGLE_W-1:0]             angle,
	output logic                                    done,
	output logic signed [rrcd_pkg::TRIG_W-1:0]      cos_q15,
	output logic signed [rrcd_pkg::TRIG_W-1:0]      sin_q15
);

	localparam int CW = rrcd_pkg::CORD_W;
	localparam int TW = rrcd_pkg::TRIG_W;

	logic signed [CW-1:0] x_q, y_q, z_q;
	logic [3:0]           iter_q;
	logic                 busy_q, flip_q, done_q;
	logic signed [TW-1:0] cos_q, sin_q;

	logic signed [CW-1:0] a_ext, a_fold;
	logic                 fold;
	logic signed [CW-1:0] dx, dy, x_nx, y_nx, z_nx, atan_ext, x_cl, y_cl;

	always_comb begin
		a_ext = CW'($signed(angle));
		fold = 1'b0;
		a_fold = a_ext;
		if (a_ext > 18'sd16384) begin
			a_fold = a_ext - 18'sd32768;
			fold = 1'b1;
		end else if (a_ext < -18'sd16384) begin
			a_fold = a_ext + 18'sd32768;
			fold = 1'b1;
		end
	end

	always_comb begin
		dx = y_q >>> iter_q;
		dy = x_q >>> iter_q;
		atan_ext = CW'($signed({1'b0, rrcd_pkg::atan_lut(iter_q)}));
		if (z_q >= 0) begin
			x_nx = x_q - dx;
			y_nx = y_q + dy;
			z_nx = z_q - atan_ext;
		end else begin
			x_nx = x_q + dx;
			y_nx = y_q - dy;
			z_nx = z_q + atan_ext;
		end
		x_cl = (x_nx > rrcd_pkg::Q15_MAX) ? rrcd_pkg::Q15_MAX :
			(x_nx < -rrcd_pkg::Q15_MAX) ? -rrcd_pkg::Q15_MAX : x_nx;
		y_cl = (y_nx > rrcd_pkg::Q15_MAX) ? rrcd_pkg::Q15_MAX :
			(y_nx < -rrcd_pkg::Q15_MAX) ? -rrcd_pkg::Q15_MAX : y_nx;
		if (flip_q) begin
			x_cl = -x_cl;
			y_cl = -y_cl;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			iter_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				iter_q <= '0;
			end else if (busy_q) begin
				iter_q <= iter_q + 4'd1;
				if (iter_q == 4'(rrcd_pkg::CORDIC_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= rrcd_pkg::CORDIC_X0;
			y_q    <= '0;
			z_q    <= a_fold;
			flip_q <= fold;
		end else if (busy_q) begin
			x_q <= x_nx;
			y_q <= y_nx;
			z_q <= z_nx;
			if (iter_q == 4'(rrcd_pkg::CORDIC_STEPS - 1)) begin
				cos_q <= x_cl[TW-1:0];
				sin_q <= y_cl[TW-1:0];
			end
		end
	end

	assign done    = done_q;
	assign cos_q15 = cos_q;
	assign sin_q15 = sin_q;

endmodule

`default_nettype wire

### hw/rtl/rrcd_divider.sv
// Radix-2 restoring divider: signed sum over an unsigned point count, truncated toward zero.
// One quotient bit per cycle; depends on rrcd_pkg for widths.
`default_nettype none

module rrcd_divider (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   start,
	input  wire signed [rrcd_pkg::SUM_W-1:0]      dividend,
	input  wire [rrcd_pkg::COUNT_W-1:0]           divisor,
	output logic                                  done,
	output logic signed [rrcd_pkg::SUM_W-1:0]     quotient
);

	localparam int SW = rrcd_pkg::SUM_W;
	localparam int DW = rrcd_pkg::COUNT_W;
	localparam int IW = $clog2(SW + 1);

	logic [SW-1:0] quo_q;
	logic [DW:0]   rem_q;
	logic [DW-1:0] div_q;
	logic [IW-1:0] left_q;
	logic          neg_q, busy_q, done_q;

	logic [DW:0]   rem_sh;
	logic [DW+1:0] diff;
	logic [SW-1:0] q_fix;

	always_comb begin
		rem_sh = {rem_q[DW-1:0], quo_q[SW-1]};
		diff   = {1'b0, rem_sh} - {2'b00, div_q};
		q_fix  = neg_q ? (~quo_q + 1'b1) : quo_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			left_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				left_q <= IW'(SW);
			end else if (busy_q) begin
				left_q <= left_q - 1'b1;
				if (left_q == IW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend[SW-1] ? (~dividend + 1'b1) : dividend;
			neg_q <= dividend[SW-1];
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			if (!diff[DW+1]) begin
				rem_q <= diff[DW:0];
				quo_q <= {quo_q[SW-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[SW-2:0], 1'b0};
			end
		end
	end

	// An empty run has no points; its centroid reads as zero.
	assign quotient = (div_q == '0) ? '0 : $signed(q_fix);
	assign done     = done_q;

endmodule

`default_nettype wire

### hw/rtl/reflector_run_centroid_detector_core.sv
// Reflector run centroid detector: sequencer, run accumulators and result register.
// Depends on rrcd_pkg, the three channel interfaces, rrcd_cordic and rrcd_divider.
//
// Usage. Samples arrive on the sample channel (range, intensity, scan-end mark) and are
// taken one at a time: ready is high only while the sequencer is idle. A sample whose
// intensity and range both exceed their thresholds extends the current run, up to 2047
// points; its angle is start_angle + sample index * angle_step, resolved by an iterative
// CORDIC (15 iterations) and a single 17 x 16 multiplier used twice. A sample that fails
// the test closes an open run; the centroid is then found by one serial divider used for
// x and then y (28 iterations each). The scan-end sample additionally gives a summary
// beat with the leg count, after which the scan state is cleared.
// Results leave through a one-deep output register, so the block takes the next sample
// while the last beat still waits; if the receiver stalls with a beat pending, the
// sequencer holds before its next result until the register frees.
// Reset returns the registers to their defaults and clears all scan state at once; no
// clearing pass is needed. Configuration writes are accepted in every cycle.
`default_nettype none

module reflector_run_centroid_detector_core #(
	parameter int MAX_SAMPLES = rrcd_pkg::DEF_MAX_SAMPLES
) (
	input  wire              clk,
	input  wire              arst_n,
	rrcd_sample_if.sink      sample,
	rrcd_result_if.source    result,
	rrcd_cfg_if.sink         cfg
);

	localparam int CNT_W = $clog2(MAX_SAMPLES);
	localparam int SW    = rrcd_pkg::SUM_W;
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_SAMPLES - 1);

	// Configuration registers.
	logic [rrcd_pkg::INTEN_W-1:0] thresh_q;
	logic [rrcd_pkg::RANGE_W-1:0] min_range_q;
	logic [rrcd_pkg::ANGLE_W-1:0] start_q;
	logic [rrcd_pkg::STEP_W-1:0]  step_q;

	// Scan state.
	logic                          in_run_q;
	logic signed [SW-1:0]          sum_x_q, sum_y_q;
	logic [rrcd_pkg::COUNT_W-1:0]  count_q;
	logic [CNT_W-1:0]              smp_cnt_q;
	logic [rrcd_pkg::LEGS_W-1:0]   legs_q;

	// Current sample.
	logic [rrcd_pkg::RANGE_W-1:0]  range_q;
	logic                          end_q;
	logic [rrcd_pkg::ANGLE_W-1:0]  angle_q;

	rrcd_pkg::state_t state_q, state_nx;

	logic qual, accept, out_free;
	logic rot_start, rot_done, div_start, div_done, div_sel_y;
	logic push_leg, push_end, add_x, add_y;
	logic signed [rrcd_pkg::TRIG_W-1:0] cos_w, sin_w, mul_b;
	logic signed [rrcd_pkg::PROD_W-1:0] prod_w, prod_s1;
	logic [rrcd_pkg::PROD_W-1:0]        mag;
	logic [rrcd_pkg::PROD_W-1:0]        rnd;
	logic signed [SW-1:0]               term;
	logic signed [SW-1:0]               div_in, quot_w;
	logic signed [rrcd_pkg::COORD_W-1:0] cx_q, cy_q;

	// Output register.
	logic                                out_valid_q;
	logic                                kind_q, two_q, final_q;
	logic signed [rrcd_pkg::COORD_W-1:0] ox_q, oy_q;
	logic [rrcd_pkg::LEGS_W-1:0]         ocount_q;

	assign out_free = !out_valid_q || result.ready;
	assign qual = (sample.intensity > thresh_q) && (sample.range_mm > min_range_q);
	assign accept = sample.valid && sample.ready;

	// Configuration port.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q    <= rrcd_pkg::THRESH_RESET;
			min_range_q <= rrcd_pkg::MIN_RANGE_RESET;
			start_q     <= rrcd_pkg::START_RESET;
			step_q      <= rrcd_pkg::STEP_RESET;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				rrcd_pkg::REG_THRESHOLD: thresh_q <= cfg.data;
				rrcd_pkg::REG_MIN_RANGE: min_range_q <= cfg.data;
				rrcd_pkg::REG_START:     start_q <= cfg.data;
				rrcd_pkg::REG_STEP:      step_q <= cfg.data[rrcd_pkg::STEP_W-1:0];
				default: ;
			endcase
		end
	end

	// Next state.
	always_comb begin
		state_nx = state_q;
		case (state_q)
			rrcd_pkg::ST_IDLE: begin
				if (sample.valid) begin
					if (qual && count_q < rrcd_pkg::POINT_MAX)
						state_nx = rrcd_pkg::ST_ANGLE;
					else if (!qual && in_run_q)
						state_nx = rrcd_pkg::ST_DIVX_GO;
					else
						state_nx = rrcd_pkg::ST_STEP;
				end
			end
			rrcd_pkg::ST_ANGLE:     state_nx = rrcd_pkg::ST_ROT_GO;
			rrcd_pkg::ST_ROT_GO:    state_nx = rrcd_pkg::ST_ROT_WAIT;
			rrcd_pkg::ST_ROT_WAIT:  if (rot_done) state_nx = rrcd_pkg::ST_MUL;
			rrcd_pkg::ST_MUL:       state_nx = rrcd_pkg::ST_ACC_X;
			rrcd_pkg::ST_ACC_X:     state_nx = rrcd_pkg::ST_ACC_Y;
			rrcd_pkg::ST_ACC_Y:     state_nx = rrcd_pkg::ST_STEP;
			rrcd_pkg::ST_DIVX_GO:   state_nx = rrcd_pkg::ST_DIVX_WAIT;
			rrcd_pkg::ST_DIVX_WAIT: if (div_done) state_nx = rrcd_pkg::ST_DIVY_GO;
			rrcd_pkg::ST_DIVY_GO:   state_nx = rrcd_pkg::ST_DIVY_WAIT;
			rrcd_pkg::ST_DIVY_WAIT: if (div_done) state_nx = rrcd_pkg::ST_EMIT_LEG;
			rrcd_pkg::ST_EMIT_LEG:  if (out_free) state_nx = rrcd_pkg::ST_STEP;
			rrcd_pkg::ST_STEP:
				state_nx = end_q ? rrcd_pkg::ST_EMIT_END : rrcd_pkg::ST_IDLE;
			rrcd_pkg::ST_EMIT_END:  if (out_free) state_nx = rrcd_pkg::ST_IDLE;
			default:                state_nx = rrcd_pkg::ST_IDLE;
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		sample.ready = 1'b0;
		rot_start    = 1'b0;
		div_start    = 1'b0;
		div_sel_y    = 1'b0;
		add_x        = 1'b0;
		add_y        = 1'b0;
		push_leg     = 1'b0;
		push_end     = 1'b0;
		case (state_q)
			rrcd_pkg::ST_IDLE:      sample.ready = 1'b1;
			rrcd_pkg::ST_ROT_GO:    rot_start = 1'b1;
			rrcd_pkg::ST_ACC_X:     add_x = 1'b1;
			rrcd_pkg::ST_ACC_Y:     add_y = 1'b1;
			rrcd_pkg::ST_DIVX_GO:   div_start = 1'b1;
			rrcd_pkg::ST_DIVY_GO: begin
				div_start = 1'b1;
				div_sel_y = 1'b1;
			end
			rrcd_pkg::ST_EMIT_LEG:  push_leg = out_free;
			rrcd_pkg::ST_EMIT_END:  push_end = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= rrcd_pkg::ST_IDLE;
		else
			state_q <= state_nx;
	end

	rrcd_cordic u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (rot_start),
		.angle   (angle_q),
		.done    (rot_done),
		.cos_q15 (cos_w),
		.sin_q15 (sin_w)
	);

	assign div_in = div_sel_y ? sum_y_q : sum_x_q;

	rrcd_divider u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_in),
		.divisor  (count_q),
		.done     (div_done),
		.quotient (quot_w)
	);

	// One multiplier serves the cosine term and then the sine term.
	always_comb begin
		mul_b  = (state_q == rrcd_pkg::ST_MUL) ? cos_w : sin_w;
		prod_w = $signed({1'b0, range_q}) * mul_b;
		mag    = prod_s1[rrcd_pkg::PROD_W-1] ? 33'(-prod_s1) : 33'(prod_s1);
		rnd    = (mag + 33'd16384) >> 15;
		term   = prod_s1[rrcd_pkg::PROD_W-1] ? -$signed(SW'(rnd)) : $signed(SW'(rnd));
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			range_q <= sample.range_mm;
			end_q   <= sample.scan_end;
		end
		if (state_q == rrcd_pkg::ST_ANGLE)
			angle_q <= start_q
				+ rrcd_pkg::ANGLE_W'(smp_cnt_q) * rrcd_pkg::ANGLE_W'(step_q);
		if (state_q == rrcd_pkg::ST_MUL || state_q == rrcd_pkg::ST_ACC_X)
			prod_s1 <= prod_w;
		if (state_q == rrcd_pkg::ST_DIVX_WAIT && div_done)
			cx_q <= quot_w[rrcd_pkg::COORD_W-1:0];
		if (state_q == rrcd_pkg::ST_DIVY_WAIT && div_done)
			cy_q <= quot_w[rrcd_pkg::COORD_W-1:0];
	end

	// Run and scan state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_run_q  <= 1'b0;
			sum_x_q   <= '0;
			sum_y_q   <= '0;
			count_q   <= '0;
			smp_cnt_q <= '0;
			legs_q    <= '0;
		end else begin
			if (accept && qual)
				in_run_q <= 1'b1;
			if (add_x)
				sum_x_q <= sum_x_q + term;
			if (add_y) begin
				sum_y_q <= sum_y_q + term;
				count_q <= count_q + 1'b1;
			end
			if (push_leg) begin
				in_run_q <= 1'b0;
				sum_x_q  <= '0;
				sum_y_q  <= '0;
				count_q  <= '0;
				if (legs_q < rrcd_pkg::LEGS_MAX)
					legs_q <= legs_q + 1'b1;
			end
			if (state_q == rrcd_pkg::ST_STEP && smp_cnt_q < CNT_LAST)
				smp_cnt_q <= smp_cnt_q + 1'b1;
			// A run still open at the end of the scan is dropped without a centroid.
			if (push_end) begin
				in_run_q  <= 1'b0;
				sum_x_q   <= '0;
				sum_y_q   <= '0;
				count_q   <= '0;
				smp_cnt_q <= '0;
				legs_q    <= '0;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (push_leg || push_end)
			out_valid_q <= 1'b1;
		else if (result.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (push_leg) begin
			kind_q   <= rrcd_pkg::KIND_LEG;
			ox_q     <= cx_q;
			oy_q     <= cy_q;
			ocount_q <= '0;
			two_q    <= 1'b0;
			final_q  <= !end_q;
		end else if (push_end) begin
			kind_q   <= rrcd_pkg::KIND_SUMMARY;
			ox_q     <= '0;
			oy_q     <= '0;
			ocount_q <= legs_q;
			two_q    <= (legs_q == rrcd_pkg::LEGS_PAIR);
			final_q  <= 1'b1;
		end
	end

	assign result.valid     = out_valid_q;
	assign result.kind      = kind_q;
	assign result.leg_x_mm  = ox_q;
	assign result.leg_y_mm  = oy_q;
	assign result.leg_count = ocount_q;
	assign result.found_two = two_q;
	assign result.final_res = final_q;

endmodule

`default_nettype wire
